// ----- rtl/hdt_pkg.sv -----
// Shared constants, types and the hex digit decoder for the hex dump text decoder.
package hdt_pkg;

   // Line buffer geometry
   localparam int LINE_CAPACITY  = 80;
   localparam int ADDR_W         = $clog2(LINE_CAPACITY);
   localparam int CHAR_W         = 8;

   // Offset field: eight uppercase hex digits
   localparam int NIB_W          = 4;
   localparam int OFS_DIGITS     = 8;
   localparam int OFS_IDX_W      = $clog2(OFS_DIGITS);
   localparam int OFS_W          = OFS_DIGITS * NIB_W;
   localparam int INDEX_W        = OFS_W - NIB_W;

   // Data pairs on one line
   localparam int BYTES_PER_LINE = 16;
   localparam int BYTE_IDX_W     = $clog2(BYTES_PER_LINE);
   localparam int COUNT_W        = BYTE_IDX_W + 1;
   localparam int FIRST_COL      = 11;
   localparam int PAIR_STEP      = 3;
   localparam int GROUP_STEP     = 5;
   localparam int HALF_BYTES     = BYTES_PER_LINE / 2;
   localparam int MIN_FULL_LEN   = LINE_CAPACITY - BYTES_PER_LINE;

   // Result kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFFSET_ERR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LONG_ERR   = 2'd2;

   // Special characters
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] BAD_BYTE = 8'hFF;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFS_RD,
      ST_OFS_USE,
      ST_CHECK,
      ST_ERR,
      ST_HI_RD,
      ST_HI_USE,
      ST_LO_USE,
      ST_HALT
   } state_type;

   // Decoded digit: bit 4 flags a non-digit, bits 3:0 hold the value
   typedef logic [NIB_W:0] digit_type;

   function automatic digit_type hex_digit(input logic [CHAR_W-1:0] ch);
      digit_type d;
      d = {1'b1, {NIB_W{1'b0}}};
      if (ch inside {["0":"9"]}) begin
         d = {1'b0, NIB_W'(ch - 8'h30)};
      end else if (ch inside {["A":"F"]}) begin
         d = {1'b0, NIB_W'(ch - 8'h37)};
      end
      return d;
   endfunction

endpackage

// ----- rtl/hdt_ram.sv -----
// Generic single-port RAM with registered read data.
module hdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ----- rtl/hex_dump_text_to_binary_core.sv -----
// Hex dump text to binary: line buffer, offset check and pair decoding sequencer.
// Characters are taken one per cycle while idle and the output is free.
// At line end the sequencer reads the 8 offset characters through the line RAM
// with a read and a use state each, compares the offset, then decodes up to 16
// data bytes with a read and two use states each, waiting on a full output.
// The single RAM port and the one shared digit decoder set this sequence.
// Synchronous active-high reset clears the line, the line count and the halt.
module hex_dump_text_to_binary_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hdt_pkg::CHAR_W-1:0]    req_tdata,   // text_char
   input  logic                          req_tlast,   // final_char
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hdt_pkg::CHAR_W-1:0]    rsp_tdata,   // data_byte
   output logic [hdt_pkg::KIND_W-1:0]    rsp_tuser,   // kind
   output logic                          rsp_tlast    // run_last
);

   import hdt_pkg::*;

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         len_ff, len_in;
   logic [ADDR_W-1:0]         eff_ff, eff_in;
   logic                      zero_ff, zero_in;
   logic [OFS_IDX_W-1:0]      idx_ff, idx_in;
   logic [OFS_W-1:0]          acc_ff, acc_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [BYTE_IDX_W-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0]         col_ff, col_in;
   digit_type                 hi_ff, hi_in;

   logic                      out_valid_ff;
   logic [KIND_W-1:0]         out_kind_ff;
   logic [CHAR_W-1:0]         out_byte_ff;
   logic                      out_last_ff;

   logic                      out_load;
   logic [KIND_W-1:0]         load_kind;
   logic [CHAR_W-1:0]         load_byte;
   logic                      load_last;
   logic                      out_free;

   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_addr;
   logic [CHAR_W-1:0]         ram_rdata;
   digit_type                 dig;

   logic                      accept;
   logic                      is_store;
   logic                      is_end;
   logic                      is_nul;
   logic [ADDR_W-1:0]         col_next;
   logic                      byte_last;

   hdt_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_CAPACITY)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_tdata),
      .rdata (ram_rdata)
   );

   // Shared digit decoder on the RAM read word
   assign dig = hex_digit(ram_rdata);

   assign accept    = req_tvalid && req_tready;
   assign is_store  = (req_tdata != CH_LF) && (req_tdata != CH_CR);
   assign is_end    = (req_tdata == CH_LF) || req_tlast;
   assign is_nul    = is_store && (req_tdata == CH_NUL);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign col_next  = col_ff + ADDR_W'(1);
   assign byte_last = ({1'b0, k_ff} + COUNT_W'(1)) == count_ff;

   // Sequencer: next state, RAM port and result load
   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      eff_in     = eff_ff;
      zero_in    = zero_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      col_in     = col_ff;
      hi_in      = hi_ff;
      ram_we     = 1'b0;
      ram_addr   = len_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      load_kind  = KIND_DATA;
      load_byte  = CH_NUL;
      load_last  = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (accept) begin
               if (is_store && (len_ff >= ADDR_W'(LINE_CAPACITY - 1))) begin
                  out_load  = 1'b1;
                  load_kind = KIND_LONG_ERR;
                  state_in  = ST_HALT;
               end else begin
                  if (is_store) begin
                     ram_we = 1'b1;
                     len_in = len_ff + ADDR_W'(1);
                  end
                  if (is_nul && !zero_ff) begin
                     zero_in = 1'b1;
                     eff_in  = len_ff;
                  end
                  if (is_end) begin
                     len_in   = '0;
                     zero_in  = 1'b0;
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = ST_OFS_RD;
                     if (zero_ff) begin
                        eff_in = eff_ff;
                     end else if (is_nul) begin
                        eff_in = len_ff;
                     end else begin
                        eff_in = len_ff + ADDR_W'(is_store);
                     end
                  end
               end
            end
         end

         ST_OFS_RD: begin
            ram_addr = ADDR_W'(idx_ff);
            state_in = ST_OFS_USE;
         end

         // Shift one offset digit in, or fail on a bad or missing one
         ST_OFS_USE: begin
            ram_addr = ADDR_W'(idx_ff);
            if (dig[NIB_W] || (ADDR_W'(idx_ff) >= eff_ff)) begin
               state_in = ST_ERR;
            end else begin
               acc_in = {acc_ff[OFS_W-NIB_W-1:0], dig[NIB_W-1:0]};
               idx_in = idx_ff + OFS_IDX_W'(1);
               if (idx_ff == OFS_IDX_W'(OFS_DIGITS - 1)) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_OFS_RD;
               end
            end
         end

         ST_CHECK: begin
            if (acc_ff == {index_ff, {NIB_W{1'b0}}}) begin
               index_in = index_ff + INDEX_W'(1);
               if (eff_ff >= ADDR_W'(MIN_FULL_LEN)) begin
                  count_in = COUNT_W'(eff_ff - ADDR_W'(MIN_FULL_LEN - 1));
                  k_in     = '0;
                  col_in   = ADDR_W'(FIRST_COL);
                  state_in = ST_HI_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_ERR;
            end
         end

         ST_ERR: begin
            if (out_free) begin
               out_load  = 1'b1;
               load_kind = KIND_OFFSET_ERR;
               state_in  = ST_HALT;
            end
         end

         ST_HI_RD: begin
            ram_addr = col_ff;
            state_in = ST_HI_USE;
         end

         ST_HI_USE: begin
            ram_addr = col_next;
            hi_in    = dig;
            state_in = ST_LO_USE;
         end

         // Form one byte, then advance to the next pair or go idle after the last
         ST_LO_USE: begin
            ram_addr = col_next;
            if (out_free) begin
               out_load  = 1'b1;
               load_kind = KIND_DATA;
               load_last = byte_last;
               if (hi_ff[NIB_W] || dig[NIB_W] || (col_next >= eff_ff)) begin
                  load_byte = BAD_BYTE;
               end else begin
                  load_byte = {hi_ff[NIB_W-1:0], dig[NIB_W-1:0]};
               end
               if (byte_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + BYTE_IDX_W'(1);
                  state_in = ST_HI_RD;
                  if (k_ff == BYTE_IDX_W'(HALF_BYTES - 1)) begin
                     col_in = col_ff + ADDR_W'(GROUP_STEP);
                  end else begin
                     col_in = col_ff + ADDR_W'(PAIR_STEP);
                  end
               end
            end
         end

         // Drop everything until reset
         ST_HALT: begin
            req_tready = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         zero_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         zero_ff  <= zero_in;
         index_ff <= index_in;
      end
   end

   // Working registers of the sequencer
   always_ff @(posedge clock) begin
      eff_ff   <= eff_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
      k_ff     <= k_in;
      col_ff   <= col_in;
      hi_ff    <= hi_in;
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= load_kind;
         out_byte_ff <= load_byte;
         out_last_ff <= load_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- rtl/hdt_checker.sv -----
// Port checker for the hex dump text decoder, bound to the top level.
module hdt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [hdt_pkg::CHAR_W-1:0] req_tdata,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [hdt_pkg::CHAR_W-1:0] rsp_tdata,
   input logic [hdt_pkg::KIND_W-1:0] rsp_tuser,
   input logic                       rsp_tlast
);

   import hdt_pkg::*;

   // An error result always closes its run
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_DATA) |-> rsp_tlast)
      else $error("error result without tlast");

   // An error result carries a zero data byte
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_DATA) |-> (rsp_tdata == CH_NUL))
      else $error("error result with nonzero data");

   // Nothing follows a taken error result
   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser != KIND_DATA) |=> !rsp_tvalid)
      else $error("result after error");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata)
         && $stable(req_tlast))
      else $error("waiting request changed");

endmodule

bind hex_dump_text_to_binary_core hdt_checker u_hdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
